// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion wrappers used by the checker file prd_sva.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while reset is released
`define PRD_ASSERT_RUN(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// property checked at every edge, reset included
`define PRD_ASSERT_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");

`endif

// ===== hw/rtl/prd_pkg.sv =====
// ----------------------------------------------------------------------------
// prd_pkg
// types, widths and divisor tables of the power-of-three rounding divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prd_pkg;

    localparam int DIV_W      = 31;
    localparam int MAG_W      = 31;
    localparam int KW         = 5;
    localparam int MAX_DIGITS = 19;
    localparam int RCP_W      = 32;
    localparam int FRAC_W     = 31;
    localparam int ADDR_W     = 3;
    localparam int PDATA_W    = 32;

    typedef logic [DIV_W-1:0]  t_div;
    typedef logic [MAG_W-1:0]  t_mag;
    typedef logic [KW-1:0]     t_idx;
    typedef logic [RCP_W-1:0]  t_rcp;
    typedef logic [ADDR_W-3:0] t_regidx;

    localparam t_regidx REG_DIGIT_SHIFT = '0;

    typedef struct packed {
        logic vld;
        logic neg;
        t_idx idx;
    } t_ctl;

    // 3^k
    function automatic t_mag pow3(input t_idx idx);
        t_mag v;
        unique case (idx)
            5'd0:    v = 31'd1;
            5'd1:    v = 31'd3;
            5'd2:    v = 31'd9;
            5'd3:    v = 31'd27;
            5'd4:    v = 31'd81;
            5'd5:    v = 31'd243;
            5'd6:    v = 31'd729;
            5'd7:    v = 31'd2187;
            5'd8:    v = 31'd6561;
            5'd9:    v = 31'd19683;
            5'd10:   v = 31'd59049;
            5'd11:   v = 31'd177147;
            5'd12:   v = 31'd531441;
            5'd13:   v = 31'd1594323;
            5'd14:   v = 31'd4782969;
            5'd15:   v = 31'd14348907;
            5'd16:   v = 31'd43046721;
            5'd17:   v = 31'd129140163;
            5'd18:   v = 31'd387420489;
            default: v = 31'd1162261467;
        endcase
        return v;
    endfunction

    // floor(2^31 / 3^k)
    function automatic t_rcp recip(input t_idx idx);
        t_rcp v;
        unique case (idx)
            5'd0:    v = 32'd2147483648;
            5'd1:    v = 32'd715827882;
            5'd2:    v = 32'd238609294;
            5'd3:    v = 32'd79536431;
            5'd4:    v = 32'd26512143;
            5'd5:    v = 32'd8837381;
            5'd6:    v = 32'd2945793;
            5'd7:    v = 32'd981931;
            5'd8:    v = 32'd327310;
            5'd9:    v = 32'd109103;
            5'd10:   v = 32'd36367;
            5'd11:   v = 32'd12122;
            5'd12:   v = 32'd4040;
            5'd13:   v = 32'd1346;
            5'd14:   v = 32'd448;
            5'd15:   v = 32'd149;
            5'd16:   v = 32'd49;
            5'd17:   v = 32'd16;
            5'd18:   v = 32'd5;
            default: v = 32'd1;
        endcase
        return v;
    endfunction

    // (3^k + 1) / 2, smallest remainder that rounds up
    function automatic t_mag half_up(input t_idx idx);
        logic [MAG_W:0] s;
        s = {1'b0, pow3(idx)} + (MAG_W+1)'(1);
        return s[MAG_W:1];
    endfunction

    // 3^k + (3^k + 1) / 2
    function automatic t_mag upper(input t_idx idx);
        logic [MAG_W:0] s;
        s = {1'b0, pow3(idx)} + {1'b0, half_up(idx)};
        return s[MAG_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/prd_recip.sv =====
// ----------------------------------------------------------------------------
// prd_recip
// reciprocal multiply for the trial quotient, then back multiply by 3^k
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prd_recip (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  prd_pkg::t_ctl i_ctl,
    input  prd_pkg::t_mag i_mag,
    output prd_pkg::t_ctl o_ctl,
    output prd_pkg::t_mag o_mag,
    output prd_pkg::t_mag o_q0,
    output prd_pkg::t_mag o_prod
);
    import prd_pkg::*;

    logic [MAG_W+RCP_W-1:0] w_p1;
    logic [2*MAG_W-1:0]     w_p2;

    t_ctl r_s2_ctl;
    t_mag r_s2_mag;
    t_mag r_s2_q0;
    t_ctl r_s3_ctl;
    t_mag r_s3_mag;
    t_mag r_s3_q0;
    t_mag r_s3_prod;

    assign w_p1 = (MAG_W+RCP_W)'(i_mag) * (MAG_W+RCP_W)'(recip(i_ctl.idx));
    assign w_p2 = (2*MAG_W)'(r_s2_q0) * (2*MAG_W)'(pow3(r_s2_ctl.idx));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl.vld <= 1'b0;
            r_s3_ctl.vld <= 1'b0;
        end else begin
            r_s2_ctl <= i_ctl;
            r_s3_ctl <= r_s2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_mag  <= i_mag;
        r_s2_q0   <= w_p1[FRAC_W+MAG_W-1:FRAC_W];
        r_s3_mag  <= r_s2_mag;
        r_s3_q0   <= r_s2_q0;
        r_s3_prod <= w_p2[MAG_W-1:0];
    end

    assign o_ctl  = r_s3_ctl;
    assign o_mag  = r_s3_mag;
    assign o_q0   = r_s3_q0;
    assign o_prod = r_s3_prod;

endmodule

// ===== hw/rtl/prd_fix.sv =====
// ----------------------------------------------------------------------------
// prd_fix
// remainder check, rounding step and sign restore
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prd_fix (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  prd_pkg::t_ctl i_ctl,
    input  prd_pkg::t_mag i_mag,
    input  prd_pkg::t_mag i_q0,
    input  prd_pkg::t_mag i_prod,
    output logic          o_valid,
    output prd_pkg::t_div o_quot
);
    import prd_pkg::*;

    t_mag       w_rem;
    logic [1:0] w_inc;
    t_mag       w_q;
    t_div       w_res;

    t_ctl       r_s4_ctl;
    t_mag       r_s4_q0;
    logic [1:0] r_s4_inc;
    logic       r_out_vld;
    t_div       r_out_quot;

    // trial quotient is exact or one short, so the remainder lies below 2 * 3^k
    assign w_rem = i_mag - i_prod;
    assign w_inc = {1'b0, (w_rem >= half_up(i_ctl.idx))}
                 + {1'b0, (w_rem >= upper(i_ctl.idx))};

    assign w_q   = r_s4_q0 + MAG_W'(r_s4_inc);
    assign w_res = r_s4_ctl.neg ? (~w_q + MAG_W'(1)) : w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctl.vld <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_s4_ctl  <= i_ctl;
            r_out_vld <= r_s4_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_q0    <= i_q0;
        r_s4_inc   <= w_inc;
        r_out_quot <= w_res;
    end

    assign o_valid = r_out_vld;
    assign o_quot  = r_out_quot;

endmodule

// ===== hw/rtl/pow3_round_divider_core.sv =====
// ----------------------------------------------------------------------------
// pow3_round_divider_core
// signed division by 3^k, rounded to nearest, five-stage pipeline
// ----------------------------------------------------------------------------
// usage
//   configuration: apb port, register 0 at byte address 0 holds digit_shift
//   (k, 5 bits); values above 19 act as 19. write it only while no result is
//   outstanding. pready is always high, reads return the register
//   input: i_dividend is taken at a rising edge with start high and busy low.
//   busy never rises, so one transfer can be taken in every cycle
//   output: o_quotient is shown with o_valid for exactly one cycle, once the
//   transfer has passed all register stages; results leave in input order.
//   the receiver has no way to hold them back
//   the path has five register stages: input register, reciprocal
//   multiply, back multiply by 3^k, remainder compare, sign restore
//   throughput: one transfer per clock
//   reset (synchronous, active low) clears digit_shift to 0 and drops every
//   item in flight; o_valid is low in the cycle after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pow3_round_divider_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [prd_pkg::DIV_W-1:0] i_dividend,
    output logic                          o_valid,
    output logic signed [prd_pkg::DIV_W-1:0] o_quotient,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prd_pkg::ADDR_W-1:0]    paddr,
    input  logic [prd_pkg::PDATA_W-1:0]   pwdata,
    output logic [prd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import prd_pkg::*;

    logic    w_cfg_wr;
    t_regidx w_regidx;
    t_div    w_raw;
    t_mag    w_mag;
    t_idx    w_idx;
    t_ctl    w_s3_ctl;
    t_mag    w_s3_mag;
    t_mag    w_s3_q0;
    t_mag    w_s3_prod;
    t_div    w_quot;

    t_idx    r_digit_shift;
    t_ctl    r_s1_ctl;
    t_mag    r_s1_mag;

    assign pready   = 1'b1;
    assign busy     = 1'b0;
    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign w_regidx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_shift <= '0;
        end else if (w_cfg_wr && (w_regidx == REG_DIGIT_SHIFT)) begin
            r_digit_shift <= pwdata[KW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_regidx == REG_DIGIT_SHIFT) begin
            prdata = PDATA_W'(r_digit_shift);
        end
    end

    // magnitude and saturated digit count
    assign w_raw = t_div'(i_dividend);
    assign w_mag = w_raw[DIV_W-1] ? t_mag'(~w_raw + DIV_W'(1)) : t_mag'(w_raw);
    assign w_idx = (r_digit_shift > KW'(MAX_DIGITS)) ? KW'(MAX_DIGITS) : r_digit_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl.vld <= 1'b0;
        end else begin
            r_s1_ctl.vld <= start & ~busy;
            r_s1_ctl.neg <= w_raw[DIV_W-1];
            r_s1_ctl.idx <= w_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_mag <= w_mag;
    end

    prd_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_s1_ctl),
        .i_mag   (r_s1_mag),
        .o_ctl   (w_s3_ctl),
        .o_mag   (w_s3_mag),
        .o_q0    (w_s3_q0),
        .o_prod  (w_s3_prod)
    );

    prd_fix u_fix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_s3_ctl),
        .i_mag   (w_s3_mag),
        .i_q0    (w_s3_q0),
        .i_prod  (w_s3_prod),
        .o_valid (o_valid),
        .o_quot  (w_quot)
    );

    assign o_quotient = signed'(w_quot);

endmodule

// ===== hw/rtl/prd_sva.sv =====
// ----------------------------------------------------------------------------
// prd_sva
// port-level checks on the divider core, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module prd_sva (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic signed [prd_pkg::DIV_W-1:0]  i_dividend,
    input logic                              o_valid,
    input logic signed [prd_pkg::DIV_W-1:0]  o_quotient
);
    import prd_pkg::*;

    // one strobe for each transfer taken with no reset between
    `PRD_ASSERT_ALL(a_strobe_follows_start, i_clk, (i_rst_n ? 1'b1 : 1'b1) && ($past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3) && $past(i_rst_n, 4) && $past(i_rst_n, 5)) |-> (o_valid == ($past(start, 5) && !$past(busy, 5))))

    `PRD_ASSERT_ALL(a_quiet_after_reset, i_clk, $past(!i_rst_n) |-> !o_valid)

    // a non-negative dividend never yields a negative quotient
    `PRD_ASSERT_RUN(a_sign_kept, i_clk, i_rst_n, o_valid |-> (!o_quotient[DIV_W-1] || $past(i_dividend[DIV_W-1], 5)))

    `PRD_ASSERT_RUN(a_zero_in_zero_out, i_clk, i_rst_n, (o_valid && ($past(i_dividend, 5) == '0)) |-> (o_quotient == '0))

endmodule

bind pow3_round_divider_core prd_sva u_prd_sva (.*);

// ===== tb/sv/tb_pow3_round_divider_core.sv =====
// ----------------------------------------------------------------------------
// tb_pow3_round_divider_core
// self-checking bench for the rounding divide-by-3^k pipeline
// ----------------------------------------------------------------------------
// dividends are queued by the stimulus process and issued by a clocked driver
// with random idle gaps. each accepted transfer is run through a local
// rounding-division predictor at the current digit count, and the expected
// quotient is compared by the monitor with the next strobed result. the digit
// count is reprogrammed over apb between phases, once the pipeline is empty,
// covering zero, nineteen, saturating values and a write to an unmapped slot
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pow3_round_divider_core;

    import prd_pkg::*;

    localparam int      CLK_HALF        = 5;
    localparam int      RESET_CYCLES    = 3;
    localparam int      PIPE_LATENCY    = 5;
    localparam int      ITEMS_PER_PHASE = 104;
    localparam int      TIMEOUT_NS      = 5_000_000;
    localparam longint  NOMINAL_MAX     = 581130733;
    localparam longint  HALF_SPAN       = 64'd1073741824;
    localparam t_regidx REG_UNMAPPED    = '1;

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      start      = 1'b0;
    logic                      busy;
    logic signed [DIV_W-1:0]   i_dividend = '0;
    logic                      o_valid;
    logic signed [DIV_W-1:0]   o_quotient;
    logic                      psel       = 1'b0;
    logic                      penable    = 1'b0;
    logic                      pwrite     = 1'b0;
    logic [ADDR_W-1:0]         paddr      = '0;
    logic [PDATA_W-1:0]        pwdata     = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    t_div  dividends_pending[$];
    t_div  quotients_due[$];
    t_idx  shift_k    = '0;
    int    mismatches = 0;
    int    idle_left  = 0;
    bit    no_idle    = 1'b0;

    pow3_round_divider_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_dividend (i_dividend),
        .o_valid    (o_valid),
        .o_quotient (o_quotient),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic longint unsigned divisor_of(input t_idx k);
        longint unsigned d;
        int              digits;
        int              i;
        digits = (k > MAX_DIGITS) ? MAX_DIGITS : int'(k);
        d = 1;
        for (i = 0; i < digits; i++) d = d * 3;
        return d;
    endfunction

    // magnitude divide, round half away from zero, then restore the sign
    function automatic t_div nearest_div_pow3(input t_div dvd, input t_idx k);
        longint unsigned mag;
        longint unsigned d;
        longint unsigned q;
        longint unsigned r;
        d   = divisor_of(k);
        mag = dvd[DIV_W-1] ? (2 * HALF_SPAN - longint'(dvd)) : longint'(dvd);
        q   = mag / d;
        r   = mag - q * d;
        if (2 * r > d) q = q + 1;
        if (dvd[DIV_W-1]) q = -q;
        return t_div'(q);
    endfunction

    // mostly rounding boundaries and wide patterns, some small values
    function automatic t_div random_dividend(input t_idx k);
        longint d;
        longint half;
        longint m;
        longint v;
        d    = longint'(divisor_of(k));
        half = (d - 1) / 2;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = longint'($urandom);
            4, 5:       v = longint'($urandom_range(0, 2 * NOMINAL_MAX)) - NOMINAL_MAX;
            6, 7, 8: begin
                m = longint'($urandom_range(0, int'(HALF_SPAN / d)));
                v = m * d + half + longint'($urandom_range(0, 3)) - 1;
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            default:    v = longint'($urandom_range(0, 10)) - 5;
        endcase
        return t_div'(v);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic apb_access(input bit wr, input t_regidx idx, input logic [PDATA_W-1:0] data,
                              output logic [PDATA_W-1:0] rd);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (wr && idx == REG_DIGIT_SHIFT) shift_k = data[KW-1:0];
    endtask

    task automatic check_readback();
        logic [PDATA_W-1:0] rd;
        apb_access(1'b0, REG_DIGIT_SHIFT, '0, rd);
        if (rd[KW-1:0] !== shift_k)
            report_mismatch($sformatf("digit_shift read %0d, want %0d", rd[KW-1:0], shift_k));
    endtask

    task automatic load_random(input int count);
        int i;
        no_idle = ($urandom_range(0, 3) == 0);
        for (i = 0; i < count; i++) dividends_pending.push_back(random_dividend(shift_k));
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (dividends_pending.size() != 0 || start || quotients_due.size() != 0);
    endtask

    // driver: start stays high back to back unless a gap is drawn or the queue is empty
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start      <= 1'b0;
            i_dividend <= '0;
            idle_left   = 0;
        end else begin
            if (start && !busy) quotients_due.push_back(nearest_div_pow3(i_dividend, shift_k));
            if (start && busy) begin
                start <= 1'b1;
            end else if (idle_left > 0) begin
                start    <= 1'b0;
                idle_left = idle_left - 1;
            end else if (dividends_pending.size() != 0) begin
                start      <= 1'b1;
                i_dividend <= dividends_pending.pop_front();
                idle_left   = pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: one strobed transfer per cycle, no back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (quotients_due.size() == 0) begin
                report_mismatch($sformatf("unexpected quotient %0d", o_quotient));
            end else begin
                if (o_quotient !== quotients_due[0])
                    report_mismatch($sformatf("quotient %0d, want %0d (k=%0d)",
                                              o_quotient, $signed(quotients_due[0]), shift_k));
                void'(quotients_due.pop_front());
            end
        end
    end

    initial begin
        logic [PDATA_W-1:0] shift_writes[11];
        logic [PDATA_W-1:0] rd;
        shift_writes = '{32'd19, 32'hFFFF_FFFF, 32'd1, 32'hAAAA_AAA0, 32'd20, 32'd10,
                         32'd2, 32'd18, 32'd7, 32'd14, 32'h5555_554D};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pass-through at the reset digit count
        dividends_pending.push_back(t_div'(0));
        dividends_pending.push_back(t_div'(1));
        dividends_pending.push_back(t_div'(-1));
        dividends_pending.push_back(t_div'(HALF_SPAN - 1));
        dividends_pending.push_back(t_div'(-HALF_SPAN));
        dividends_pending.push_back(t_div'(NOMINAL_MAX));
        dividends_pending.push_back(t_div'(-NOMINAL_MAX));
        load_random(ITEMS_PER_PHASE);
        wait_drained();

        foreach (shift_writes[n]) begin
            apb_access(1'b1, REG_DIGIT_SHIFT, shift_writes[n], rd);
            check_readback();
            if (shift_writes[n] == 32'hAAAA_AAA0) begin
                apb_access(1'b1, REG_UNMAPPED, 32'd5, rd);
                check_readback();
            end
            if (shift_writes[n] == 32'd19) begin
                // largest divisor, half-way points at the nominal range edge
                dividends_pending.push_back(t_div'(NOMINAL_MAX));
                dividends_pending.push_back(t_div'(NOMINAL_MAX + 1));
                dividends_pending.push_back(t_div'(-NOMINAL_MAX));
                dividends_pending.push_back(t_div'(-(NOMINAL_MAX + 1)));
                dividends_pending.push_back(t_div'(HALF_SPAN - 1));
                dividends_pending.push_back(t_div'(-HALF_SPAN));
                dividends_pending.push_back(t_div'(0));
            end
            if (shift_writes[n] == 32'd1) begin
                dividends_pending.push_back(t_div'(1));
                dividends_pending.push_back(t_div'(2));
                dividends_pending.push_back(t_div'(-1));
                dividends_pending.push_back(t_div'(-2));
            end
            load_random(ITEMS_PER_PHASE);
            wait_drained();
        end

        repeat (PIPE_LATENCY + 5) @(posedge i_clk);
        if (quotients_due.size() != 0)
            report_mismatch($sformatf("%0d quotients never arrived", quotients_due.size()));
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
